FILE: design/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros
// Assertion helpers shared by the regulator modules.
// Each macro expects signals named clk and rst in the module that uses it.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define PIPR_ASSERT_IMM(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define PIPR_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: design/pipr_pkg.sv
// ----------------------------------------------------------------------------
// pipr_pkg
// Shared widths, constants, configuration and controller/datapath interface
// types of the PI pressure regulator.
// ----------------------------------------------------------------------------
package pipr_pkg;

  localparam int NOW_W    = 32;
  localparam int LEVEL_W  = 17;
  localparam int DRIVE_W  = 16;
  localparam int TARGET_W = 13;
  localparam int ACC_W    = 27;
  localparam int DT_W     = 16;
  localparam int ERR_W    = 18;
  localparam int PROP_W   = 24;
  localparam int IQ_W     = 18;
  localparam int CAND_W   = 26;
  localparam int DELTA_W  = 40;
  localparam int SUM_W    = 41;
  localparam int MUL_W    = 28;
  localparam int PROD_W   = 2 * MUL_W;
  localparam int ADDR_W   = 5;
  localparam int DATA_W   = 32;

  // floor(y / 125) = (y * RECIP125) >> RECIP_SHIFT, exact for y below 2^25
  localparam logic [25:0] RECIP125    = 26'd34359739;
  localparam int          RECIP_SHIFT = 32;

  localparam logic [TARGET_W-1:0] TARGET_BASE = 13'd4000;
  localparam logic [15:0]         SET_MAX     = 16'd50000;
  localparam logic [9:0]          INTEG_SCALE = 10'd1000;
  localparam logic [DT_W-1:0]     ELAPSED_SAT = 16'hFFFF;

  typedef struct packed {
    logic [9:0]  period_ms;
    logic [5:0]  prop_gain;
    logic [5:0]  integ_gain;
    logic [9:0]  dead_band;
    logic [15:0] integ_limit;
    logic [15:0] drive_max;
    logic [15:0] valid_min;
    logic [15:0] valid_max;
  } cfg_t;

  typedef enum logic [2:0] {
    REG_PERIOD_MS   = 3'd0,
    REG_PROP_GAIN   = 3'd1,
    REG_INTEG_GAIN  = 3'd2,
    REG_DEAD_BAND   = 3'd3,
    REG_INTEG_LIMIT = 3'd4,
    REG_DRIVE_MAX   = 3'd5,
    REG_VALID_MIN   = 3'd6,
    REG_VALID_MAX   = 3'd7
  } cfg_idx_t;

  typedef enum logic [1:0] {
    ST_REGULATING    = 2'd0,
    ST_DISABLED      = 2'd1,
    ST_OUT_OF_WINDOW = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    MUL_NONE = 3'd0,
    MUL_TGT  = 3'd1,
    MUL_PROP = 3'd2,
    MUL_QUOT = 3'd3,
    MUL_IGE  = 3'd4,
    MUL_DT   = 3'd5,
    MUL_LIM  = 3'd6
  } mul_sel_t;

  typedef struct packed {
    logic     latch_in;
    logic     check_time;
    mul_sel_t mul_sel;
    logic     ld_target;
    logic     ld_prop;
    logic     ld_iq;
    logic     ld_delta;
    logic     upd_acc;
    logic     ld_drive;
    logic     ld_out;
  } dp_cmd_t;

  typedef struct packed {
    logic too_early;
    logic bail;
  } dp_sts_t;

endpackage

FILE: design/pi_pressure_regulator.sv
// ----------------------------------------------------------------------------
// pi_pressure_regulator
// Periodic PI pressure regulator with feedforward and anti-windup.
//   Requests arrive on in_valid/in_stall with now_ms, set_level, sensed_level
//   and enable; results leave on out_valid/out_stall with drive_out,
//   target_level and reg_status. A request is taken when valid is high and
//   stall is low. Settings are to be written over the APB-style port
//   (pready tied high) only while idle; the block does not enforce this.
//   A request earlier than period_ms after the last update gives no result;
//   the sequencer returns to idle after the time check. A disabled or
//   out-of-window request goes from the target step straight to the last
//   step and shows its result. A regulating update runs through every step:
//   the sequencer passes seven products through the single shared 28 x 28
//   multiplier, one at a time, with a register after each.
//   One request is worked on at a time; a finished result waits in the
//   output register while the next request is accepted. If the receiver
//   stalls, the result holds and the sequencer waits at its last step until
//   the register frees up.
//   Reset clears the sequencer, the result valid, the last update time and
//   the integral, and loads the default settings.
// ----------------------------------------------------------------------------
module pi_pressure_regulator (
  input  logic                                clk,
  input  logic                                rst,
  // configuration port
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [pipr_pkg::ADDR_W-1:0]         paddr,
  input  logic [pipr_pkg::DATA_W-1:0]         pwdata,
  output logic [pipr_pkg::DATA_W-1:0]         prdata,
  output logic                                pready,
  // request channel
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [pipr_pkg::NOW_W-1:0]          now_ms,
  input  logic signed [pipr_pkg::LEVEL_W-1:0] set_level,
  input  logic signed [pipr_pkg::LEVEL_W-1:0] sensed_level,
  input  logic                                enable,
  // result channel
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [pipr_pkg::DRIVE_W-1:0]        drive_out,
  output logic [pipr_pkg::TARGET_W-1:0]       target_level,
  output logic [1:0]                          reg_status
);
  import pipr_pkg::*;

  cfg_t    cfg;
  dp_cmd_t cmd;
  dp_sts_t sts;

  // settings, reset to the defaults
  pipr_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // sequencer: drives the datapath step by step and both handshakes
  pipr_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  // arithmetic, regulator state and the output register
  pipr_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .sts          (sts),
    .cfg          (cfg),
    .now_ms       (now_ms),
    .set_level    (set_level),
    .sensed_level (sensed_level),
    .enable       (enable),
    .drive_out    (drive_out),
    .target_level (target_level),
    .reg_status   (reg_status)
  );

endmodule

FILE: design/pipr_regs.sv
// ----------------------------------------------------------------------------
// pipr_regs
// Configuration register file behind the APB-style port.
// ----------------------------------------------------------------------------
module pipr_regs (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [pipr_pkg::ADDR_W-1:0]   paddr,
  input  logic [pipr_pkg::DATA_W-1:0]   pwdata,
  output logic [pipr_pkg::DATA_W-1:0]   prdata,
  output logic                          pready,
  output pipr_pkg::cfg_t                cfg
);
  import pipr_pkg::*;

  logic     wr_en;
  cfg_idx_t idx;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  assign idx    = cfg_idx_t'(paddr[4:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.period_ms   <= 10'd10;
      cfg.prop_gain   <= 6'd12;
      cfg.integ_gain  <= 6'd6;
      cfg.dead_band   <= 10'd15;
      cfg.integ_limit <= 16'd20000;
      cfg.drive_max   <= 16'd50000;
      cfg.valid_min   <= 16'd3500;
      cfg.valid_max   <= 16'd20500;
    end else if (wr_en) begin
      case (idx)
        REG_PERIOD_MS:   cfg.period_ms   <= pwdata[9:0];
        REG_PROP_GAIN:   cfg.prop_gain   <= pwdata[5:0];
        REG_INTEG_GAIN:  cfg.integ_gain  <= pwdata[5:0];
        REG_DEAD_BAND:   cfg.dead_band   <= pwdata[9:0];
        REG_INTEG_LIMIT: cfg.integ_limit <= pwdata[15:0];
        REG_DRIVE_MAX:   cfg.drive_max   <= pwdata[15:0];
        REG_VALID_MIN:   cfg.valid_min   <= pwdata[15:0];
        REG_VALID_MAX:   cfg.valid_max   <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_PERIOD_MS:   prdata = {22'b0, cfg.period_ms};
      REG_PROP_GAIN:   prdata = {26'b0, cfg.prop_gain};
      REG_INTEG_GAIN:  prdata = {26'b0, cfg.integ_gain};
      REG_DEAD_BAND:   prdata = {22'b0, cfg.dead_band};
      REG_INTEG_LIMIT: prdata = {16'b0, cfg.integ_limit};
      REG_DRIVE_MAX:   prdata = {16'b0, cfg.drive_max};
      REG_VALID_MIN:   prdata = {16'b0, cfg.valid_min};
      REG_VALID_MAX:   prdata = {16'b0, cfg.valid_max};
      default:         prdata = '0;
    endcase
  end

endmodule

FILE: design/pipr_ctrl.sv
// ----------------------------------------------------------------------------
// pipr_ctrl
// Sequencer: steps one request through the shared multiplier and owns the
// input and result handshakes.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pipr_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  input  pipr_pkg::dp_sts_t sts,
  output pipr_pkg::dp_cmd_t cmd
);
  import pipr_pkg::*;

  typedef enum logic [12:0] {
    S_IDLE = 13'b0000000000001,
    S_TIME = 13'b0000000000010,
    S_TGTM = 13'b0000000000100,
    S_TGTR = 13'b0000000001000,
    S_PRM  = 13'b0000000010000,
    S_QDM  = 13'b0000000100000,
    S_IGM  = 13'b0000001000000,
    S_DTM  = 13'b0000010000000,
    S_LMM  = 13'b0000100000000,
    S_UPD  = 13'b0001000000000,
    S_QD2  = 13'b0010000000000,
    S_DRV  = 13'b0100000000000,
    S_FIN  = 13'b1000000000000
  } state_t;

  state_t state, state_next;

  assign in_stall = (state != S_IDLE);

  always_comb begin
    cmd        = '0;
    cmd.mul_sel = MUL_NONE;
    state_next = state;
    case (state)
      S_IDLE: begin
        cmd.latch_in = in_valid;
        if (in_valid) state_next = S_TIME;
      end
      S_TIME: begin
        cmd.check_time = 1'b1;
        state_next = sts.too_early ? S_IDLE : S_TGTM;
      end
      S_TGTM: begin
        cmd.mul_sel = MUL_TGT;
        state_next  = S_TGTR;
      end
      S_TGTR: begin
        cmd.ld_target = 1'b1;
        state_next = sts.bail ? S_FIN : S_PRM;
      end
      S_PRM: begin
        cmd.mul_sel = MUL_PROP;
        state_next  = S_QDM;
      end
      S_QDM: begin
        cmd.ld_prop = 1'b1;
        cmd.mul_sel = MUL_QUOT;
        state_next  = S_IGM;
      end
      S_IGM: begin
        cmd.ld_iq   = 1'b1;
        cmd.mul_sel = MUL_IGE;
        state_next  = S_DTM;
      end
      S_DTM: begin
        cmd.mul_sel = MUL_DT;
        state_next  = S_LMM;
      end
      S_LMM: begin
        cmd.ld_delta = 1'b1;
        cmd.mul_sel  = MUL_LIM;
        state_next   = S_UPD;
      end
      S_UPD: begin
        cmd.upd_acc = 1'b1;
        state_next  = S_QD2;
      end
      S_QD2: begin
        cmd.mul_sel = MUL_QUOT;
        state_next  = S_DRV;
      end
      S_DRV: begin
        cmd.ld_drive = 1'b1;
        state_next   = S_FIN;
      end
      S_FIN: begin
        // load the output register once it is free or being drained
        if (!out_valid || !out_stall) begin
          cmd.ld_out = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.ld_out) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  `PIPR_ASSERT_IMM(a_no_overwrite, out_valid && out_stall, !cmd.ld_out, "held result overwritten")
  `PIPR_ASSERT_NXT(a_early_drop, state == S_TIME && sts.too_early, state == S_IDLE, "early request not dropped")
  `PIPR_ASSERT_NXT(a_load_shows, cmd.ld_out, out_valid && state == S_IDLE, "loaded result not shown")

endmodule

FILE: design/pipr_dp.sv
// ----------------------------------------------------------------------------
// pipr_dp
// Datapath: request registers, regulator state, one shared registered
// multiplier, integral update with anti-windup and the output register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pipr_dp (
  input  logic                            clk,
  input  logic                            rst,
  input  pipr_pkg::dp_cmd_t               cmd,
  output pipr_pkg::dp_sts_t               sts,
  input  pipr_pkg::cfg_t                  cfg,
  input  logic [pipr_pkg::NOW_W-1:0]      now_ms,
  input  logic signed [pipr_pkg::LEVEL_W-1:0] set_level,
  input  logic signed [pipr_pkg::LEVEL_W-1:0] sensed_level,
  input  logic                            enable,
  output logic [pipr_pkg::DRIVE_W-1:0]    drive_out,
  output logic [pipr_pkg::TARGET_W-1:0]   target_level,
  output logic [1:0]                      reg_status
);
  import pipr_pkg::*;

  // request registers
  logic [NOW_W-1:0]          now_q;
  logic signed [LEVEL_W-1:0] set_q;
  logic signed [LEVEL_W-1:0] sensed_q;
  logic                      en_q;

  // regulator state
  logic [NOW_W-1:0]          last_update;
  logic signed [ACC_W-1:0]   acc;

  // working registers
  logic [DT_W-1:0]           dt;
  logic [15:0]               set_c;
  logic signed [ERR_W-1:0]   err;
  logic signed [PROP_W-1:0]  prop;
  logic signed [IQ_W-1:0]    iq;
  logic signed [DELTA_W-1:0] delta;
  logic signed [PROD_W-1:0]  p;
  logic [DRIVE_W-1:0]        res_drive;
  logic [TARGET_W-1:0]       res_target;
  status_t                   res_status;

  logic [NOW_W-1:0]          elapsed;
  logic [11:0]               tgt_q;
  logic [TARGET_W-1:0]       tgt_comb;
  logic                      below, above;
  logic signed [ERR_W-1:0]   err_raw;
  logic [ERR_W-1:0]          err_mag;
  logic                      in_band;
  logic signed [MUL_W-1:0]   mul_a, mul_b;
  logic [ACC_W-1:0]          acc_mag;
  logic [16:0]               quo;
  logic signed [IQ_W-1:0]    iq_comb;
  logic signed [CAND_W-1:0]  cand, drive_s, dmax_s;
  logic                      integ_ok;
  logic signed [SUM_W-1:0]   sum, lim_s, nlim_s;
  logic signed [ACC_W-1:0]   acc_next;
  logic [DRIVE_W-1:0]        drive_clamped;

  assign elapsed       = now_q - last_update;
  assign sts.too_early = elapsed < {22'b0, cfg.period_ms};

  // target from set_c*8/125 held in the product
  assign tgt_q    = p[RECIP_SHIFT +: 12];
  assign tgt_comb = TARGET_BASE + {1'b0, tgt_q};

  assign below    = sensed_q[LEVEL_W-1] || (sensed_q[15:0] < cfg.valid_min);
  assign above    = !sensed_q[LEVEL_W-1] && (sensed_q[15:0] > cfg.valid_max);
  assign sts.bail = !en_q || below || above;

  assign err_raw = $signed({5'b0, tgt_comb}) - $signed({2'b0, sensed_q[15:0]});
  assign err_mag = err_raw[ERR_W-1] ? ERR_W'(-err_raw) : err_raw;
  assign in_band = err_mag < {8'b0, cfg.dead_band};

  assign acc_mag = acc[ACC_W-1] ? ACC_W'(-acc) : acc;

  always_comb begin
    case (cmd.mul_sel)
      MUL_TGT: begin
        mul_a = $signed({9'b0, set_c, 3'b0});
        mul_b = $signed({2'b0, RECIP125});
      end
      MUL_PROP: begin
        mul_a = $signed({22'b0, cfg.prop_gain});
        mul_b = {{(MUL_W-ERR_W){err[ERR_W-1]}}, err};
      end
      MUL_QUOT: begin
        mul_a = $signed({4'b0, acc_mag[ACC_W-1:3]});
        mul_b = $signed({2'b0, RECIP125});
      end
      MUL_IGE: begin
        mul_a = $signed({22'b0, cfg.integ_gain});
        mul_b = {{(MUL_W-ERR_W){err[ERR_W-1]}}, err};
      end
      MUL_DT: begin
        mul_a = p[MUL_W-1:0];
        mul_b = $signed({12'b0, dt});
      end
      MUL_LIM: begin
        mul_a = $signed({12'b0, cfg.integ_limit});
        mul_b = $signed({18'b0, INTEG_SCALE});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // signed quotient of acc/1000, truncated toward zero
  assign quo     = p[RECIP_SHIFT +: 17];
  assign iq_comb = acc[ACC_W-1] ? -$signed({1'b0, quo}) : $signed({1'b0, quo});

  assign dmax_s = $signed({10'b0, cfg.drive_max});
  assign cand   = $signed({10'b0, set_c}) + {{(CAND_W-PROP_W){prop[PROP_W-1]}}, prop}
                + {{(CAND_W-IQ_W){iq[IQ_W-1]}}, iq};

  // integrate only when that does not push the drive deeper into saturation
  assign integ_ok = ((cand < dmax_s) && (cand > 0))
                 || ((cand >= dmax_s) && err[ERR_W-1])
                 || ((cand <= 0) && !err[ERR_W-1] && (err != '0));

  assign sum    = {{(SUM_W-ACC_W){acc[ACC_W-1]}}, acc}
                + {{(SUM_W-DELTA_W){delta[DELTA_W-1]}}, delta};
  assign lim_s  = $signed({15'b0, p[25:0]});
  assign nlim_s = -lim_s;

  always_comb begin
    if (sum > lim_s) begin
      acc_next = lim_s[ACC_W-1:0];
    end else if (sum < nlim_s) begin
      acc_next = nlim_s[ACC_W-1:0];
    end else begin
      acc_next = sum[ACC_W-1:0];
    end
  end

  assign drive_s = $signed({10'b0, set_c}) + {{(CAND_W-PROP_W){prop[PROP_W-1]}}, prop}
                 + {{(CAND_W-IQ_W){iq_comb[IQ_W-1]}}, iq_comb};

  always_comb begin
    if (drive_s > dmax_s) begin
      drive_clamped = cfg.drive_max;
    end else if (drive_s < 0) begin
      drive_clamped = '0;
    end else begin
      drive_clamped = drive_s[DRIVE_W-1:0];
    end
  end

  // state with reset
  always_ff @(posedge clk) begin
    if (rst) begin
      last_update <= '0;
      acc         <= '0;
    end else begin
      if (cmd.check_time && !sts.too_early) begin
        last_update <= now_q;
      end
      if (cmd.ld_target && sts.bail) begin
        acc <= '0;
      end else if (cmd.upd_acc && integ_ok) begin
        acc <= acc_next;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    p <= mul_a * mul_b;
    if (cmd.latch_in) begin
      now_q    <= now_ms;
      set_q    <= set_level;
      sensed_q <= sensed_level;
      en_q     <= enable;
    end
    if (cmd.check_time) begin
      dt <= (elapsed[NOW_W-1:DT_W] != '0) ? ELAPSED_SAT : elapsed[DT_W-1:0];
      if (set_q[LEVEL_W-1]) begin
        set_c <= '0;
      end else if (set_q[15:0] > SET_MAX) begin
        set_c <= SET_MAX;
      end else begin
        set_c <= set_q[15:0];
      end
    end
    if (cmd.ld_target) begin
      res_target <= tgt_comb;
      err        <= in_band ? '0 : err_raw;
      if (sts.bail) begin
        res_drive  <= '0;
        res_status <= en_q ? ST_OUT_OF_WINDOW : ST_DISABLED;
      end
    end
    if (cmd.ld_prop) prop <= p[PROP_W-1:0];
    if (cmd.ld_iq) iq <= iq_comb;
    if (cmd.ld_delta) delta <= p[DELTA_W-1:0];
    if (cmd.ld_drive) begin
      res_drive  <= drive_clamped;
      res_status <= ST_REGULATING;
    end
    if (cmd.ld_out) begin
      drive_out    <= res_drive;
      target_level <= res_target;
      reg_status   <= res_status;
    end
  end

  `PIPR_ASSERT_NXT(a_target_range, cmd.ld_target, res_target >= 13'd4000 && res_target <= 13'd7200, "target out of range")
  `PIPR_ASSERT_NXT(a_drive_clamp, cmd.ld_drive, res_drive <= $past(cfg.drive_max), "drive above clamp")
  `PIPR_ASSERT_NXT(a_bail_clears, cmd.ld_target && sts.bail, acc == '0, "integral kept on bail")

endmodule
